// File: rtl/core/dctc_pkg.sv
// Package for the DRAM command timing checker: payload widths, command and
// delay codes, control/status structs and the per-command check list.
// No dependencies.
`timescale 1ns / 1ps
package dctc_pkg;

  localparam int NCMD = 15;
  localparam int CMD_W = 4;
  localparam int NOW_W = 40;
  localparam int CFG_W = 60;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W = 4;
  localparam int DLY_W = 6;
  localparam int KIND_W = 3;
  localparam int DEF_BANKS = 16;
  localparam int DEF_RANKS = 2;
  localparam int DEF_ACT_WINDOW = 4;
  localparam int DEF_TIME_BITS = 40;

  localparam logic [CMD_W-1:0] C_RD = 4'd0, C_WR = 4'd1, C_RDA = 4'd2, C_WRA = 4'd3,
    C_ACT = 4'd4, C_PREPB = 4'd5, C_PREAB = 4'd6, C_REFAB = 4'd7, C_REFPB = 4'd8,
    C_PDEA = 4'd9, C_PDXA = 4'd10, C_PDEP = 4'd11, C_PDXP = 4'd12, C_SREFEN = 4'd13,
    C_SREFEX = 4'd14;

  localparam logic [CFG_IDX_W-1:0] REG_TW0 = 3'd0, REG_TW1 = 3'd1, REG_TW2 = 3'd2,
    REG_TW3 = 3'd3, REG_TW4 = 3'd4, REG_TW5 = 3'd5, REG_CMDLEN = 3'd6;

  localparam logic [KIND_W-1:0] K_END = 3'd0, K_BANK = 3'd1, K_RANK = 3'd2,
    K_OTHER = 3'd3, K_FAW = 3'd4;

  localparam logic [DLY_W-1:0] D_RCD = 6'd0, D_CCD = 6'd1, D_RDWR = 6'd2, D_BRTRS = 6'd3,
    D_RDWR_R = 6'd4, D_WRPRE_RDPRE = 6'd5, D_WRRD = 6'd6, D_WRRD_R = 6'd7, D_XP = 6'd8,
    D_RCPB = 6'd9, D_RRD = 6'd10, D_RDAACT = 6'd11, D_WRAACT = 6'd12, D_RPPB_M2 = 6'd13,
    D_RPAB_M2 = 6'd14, D_RFCAB_M2 = 6'd15, D_RFCPB_M2 = 6'd16, D_RRD_M2 = 6'd17,
    D_XSR_M2 = 6'd18, D_FAW_M4 = 6'd19, D_RAS_P2 = 6'd20, D_RDPRE = 6'd21,
    D_WRPRE = 6'd22, D_PPD = 6'd23, D_RFCPB = 6'd24, D_RCPB_P2 = 6'd25,
    D_RDPRE_RPPB = 6'd26, D_WRPRE_RPPB = 6'd27, D_RPPB = 6'd28, D_RPAB = 6'd29,
    D_RFCAB = 6'd30, D_XSR = 6'd31, D_RRD_P2 = 6'd32, D_FAW_M2 = 6'd33,
    D_ACTPDEN = 6'd34, D_RDPDEN = 6'd35, D_WRPDEN = 6'd36, D_WRAPDEN = 6'd37,
    D_PRPDEN = 6'd38, D_REFPDEN = 6'd39, D_CKE = 6'd40, D_SREF_RDA = 6'd41,
    D_SREF_WRA = 6'd42, D_SR = 6'd43;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CMD_W-1:0] src;
    logic [DLY_W-1:0] dly;
  } chk_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic record;
    logic step;
    logic finish;
    logic [IDX_W-1:0] idx;
  } dctc_ctl_t;

  typedef struct packed {
    logic list_end;
    logic out_free;
  } dctc_sts_t;

  function automatic chk_t mk(input logic [KIND_W-1:0] k, input logic [CMD_W-1:0] s,
                              input logic [DLY_W-1:0] d);
    chk_t e;
    e.kind = k;
    e.src = s;
    e.dly = d;
    return e;
  endfunction

  // Constraint list of each command; the list ends at the first K_END entry.
  function automatic chk_t check_entry(input logic [CMD_W-1:0] cmd,
                                       input logic [IDX_W-1:0] idx);
    chk_t e;
    logic rd;
    e = mk(K_END, C_RD, D_RCD);
    rd = (cmd == C_RD) || (cmd == C_RDA);
    case (cmd)
      C_RD, C_WR, C_RDA, C_WRA: begin
        case (idx)
          4'd0: e = mk(K_BANK, C_ACT, D_RCD);
          4'd1: e = mk(K_RANK, C_RD, rd ? D_CCD : D_RDWR);
          4'd2: e = mk(K_OTHER, C_RD, rd ? D_BRTRS : D_RDWR_R);
          4'd3: e = mk(K_RANK, C_RDA, rd ? D_CCD : D_RDWR);
          4'd4: e = mk(K_OTHER, C_RDA, rd ? D_BRTRS : D_RDWR_R);
          4'd5: e = mk(K_RANK, C_WR, rd ? D_WRRD : D_CCD);
          4'd6: e = mk(K_OTHER, C_WR, rd ? D_WRRD_R : D_BRTRS);
          4'd7: e = mk(K_RANK, C_WRA, rd ? D_WRRD : D_CCD);
          4'd8: e = mk(K_OTHER, C_WRA, rd ? D_WRRD_R : D_BRTRS);
          4'd9: e = mk(K_RANK, C_PDXA, D_XP);
          4'd10: if (cmd == C_RDA) e = mk(K_BANK, C_WR, D_WRPRE_RDPRE);
          default: ;
        endcase
      end
      C_ACT: begin
        case (idx)
          4'd0: e = mk(K_BANK, C_ACT, D_RCPB);
          4'd1: e = mk(K_RANK, C_ACT, D_RRD);
          4'd2: e = mk(K_BANK, C_RDA, D_RDAACT);
          4'd3: e = mk(K_BANK, C_WRA, D_WRAACT);
          4'd4: e = mk(K_BANK, C_PREPB, D_RPPB_M2);
          4'd5: e = mk(K_RANK, C_PREAB, D_RPAB_M2);
          4'd6: e = mk(K_RANK, C_PDXA, D_XP);
          4'd7: e = mk(K_RANK, C_PDXP, D_XP);
          4'd8: e = mk(K_RANK, C_REFAB, D_RFCAB_M2);
          4'd9: e = mk(K_BANK, C_REFPB, D_RFCPB_M2);
          4'd10: e = mk(K_RANK, C_REFPB, D_RRD_M2);
          4'd11: e = mk(K_RANK, C_SREFEX, D_XSR_M2);
          4'd12: e = mk(K_FAW, C_ACT, D_FAW_M4);
          default: ;
        endcase
      end
      C_PREPB: begin
        case (idx)
          4'd0: e = mk(K_BANK, C_ACT, D_RAS_P2);
          4'd1: e = mk(K_BANK, C_RD, D_RDPRE);
          4'd2: e = mk(K_BANK, C_WR, D_WRPRE);
          4'd3: e = mk(K_RANK, C_PREPB, D_PPD);
          4'd4: e = mk(K_RANK, C_PDXA, D_XP);
          default: ;
        endcase
      end
      C_PREAB: begin
        case (idx)
          4'd0: e = mk(K_RANK, C_ACT, D_RAS_P2);
          4'd1: e = mk(K_RANK, C_RD, D_RDPRE);
          4'd2: e = mk(K_RANK, C_RDA, D_RDPRE);
          4'd3: e = mk(K_RANK, C_WR, D_WRPRE);
          4'd4: e = mk(K_RANK, C_WRA, D_WRPRE);
          4'd5: e = mk(K_RANK, C_PREPB, D_PPD);
          4'd6: e = mk(K_RANK, C_PDXA, D_XP);
          4'd7: e = mk(K_RANK, C_REFPB, D_RFCPB);
          default: ;
        endcase
      end
      C_REFAB: begin
        case (idx)
          4'd0: e = mk(K_RANK, C_ACT, D_RCPB_P2);
          4'd1: e = mk(K_RANK, C_RDA, D_RDPRE_RPPB);
          4'd2: e = mk(K_RANK, C_WRA, D_WRPRE_RPPB);
          4'd3: e = mk(K_RANK, C_PREPB, D_RPPB);
          4'd4: e = mk(K_RANK, C_PREAB, D_RPAB);
          4'd5: e = mk(K_RANK, C_PDXP, D_XP);
          4'd6: e = mk(K_RANK, C_REFAB, D_RFCAB);
          4'd7: e = mk(K_RANK, C_REFPB, D_RFCPB);
          4'd8: e = mk(K_RANK, C_SREFEX, D_XSR);
          default: ;
        endcase
      end
      C_REFPB: begin
        case (idx)
          4'd0: e = mk(K_BANK, C_ACT, D_RCPB_P2);
          4'd1: e = mk(K_RANK, C_ACT, D_RRD_P2);
          4'd2: e = mk(K_BANK, C_RDA, D_RDPRE_RPPB);
          4'd3: e = mk(K_BANK, C_WRA, D_WRPRE_RPPB);
          4'd4: e = mk(K_BANK, C_PREPB, D_RPPB);
          4'd5: e = mk(K_RANK, C_PREAB, D_RPAB);
          4'd6: e = mk(K_RANK, C_PDXA, D_XP);
          4'd7: e = mk(K_RANK, C_PDXP, D_XP);
          4'd8: e = mk(K_RANK, C_REFAB, D_RFCAB);
          4'd9: e = mk(K_RANK, C_REFPB, D_RFCPB);
          4'd10: e = mk(K_RANK, C_SREFEX, D_XSR);
          4'd11: e = mk(K_FAW, C_ACT, D_FAW_M2);
          default: ;
        endcase
      end
      C_PDEA: begin
        case (idx)
          4'd0: e = mk(K_RANK, C_ACT, D_ACTPDEN);
          4'd1: e = mk(K_RANK, C_RD, D_RDPDEN);
          4'd2: e = mk(K_RANK, C_RDA, D_RDPDEN);
          4'd3: e = mk(K_RANK, C_WR, D_WRPDEN);
          4'd4: e = mk(K_RANK, C_WRA, D_WRAPDEN);
          4'd5: e = mk(K_RANK, C_PREPB, D_PRPDEN);
          4'd6: e = mk(K_RANK, C_REFPB, D_REFPDEN);
          4'd7: e = mk(K_RANK, C_PDXA, D_CKE);
          default: ;
        endcase
      end
      C_PDXA: if (idx == 4'd0) e = mk(K_RANK, C_PDEA, D_CKE);
      C_PDEP: begin
        case (idx)
          4'd0: e = mk(K_RANK, C_RD, D_RDPDEN);
          4'd1: e = mk(K_RANK, C_RDA, D_RDPDEN);
          4'd2: e = mk(K_RANK, C_WRA, D_WRAPDEN);
          4'd3: e = mk(K_RANK, C_PREPB, D_PRPDEN);
          4'd4: e = mk(K_RANK, C_PREAB, D_PRPDEN);
          4'd5: e = mk(K_RANK, C_REFAB, D_REFPDEN);
          4'd6: e = mk(K_RANK, C_REFPB, D_REFPDEN);
          4'd7: e = mk(K_RANK, C_PDXP, D_CKE);
          4'd8: e = mk(K_RANK, C_SREFEX, D_XSR);
          default: ;
        endcase
      end
      C_PDXP: if (idx == 4'd0) e = mk(K_RANK, C_PDEP, D_CKE);
      C_SREFEN: begin
        case (idx)
          4'd0: e = mk(K_RANK, C_ACT, D_RCPB_P2);
          4'd1: e = mk(K_RANK, C_RDA, D_SREF_RDA);
          4'd2: e = mk(K_RANK, C_WRA, D_SREF_WRA);
          4'd3: e = mk(K_RANK, C_PREPB, D_RPPB);
          4'd4: e = mk(K_RANK, C_PREAB, D_RPAB);
          4'd5: e = mk(K_RANK, C_PDXP, D_XP);
          4'd6: e = mk(K_RANK, C_REFAB, D_RFCAB);
          4'd7: e = mk(K_RANK, C_REFPB, D_RFCPB);
          4'd8: e = mk(K_RANK, C_SREFEX, D_XSR);
          default: ;
        endcase
      end
      C_SREFEX: if (idx == 4'd0) e = mk(K_RANK, C_SREFEN, D_SR);
      default: ;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/dctc_if.sv
// Handshake interfaces for the query/record channel and the result channel.
// Depends on dctc_pkg.
`timescale 1ns / 1ps
interface dctc_in_if import dctc_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  logic [CMD_W-1:0] command;
  logic [3:0] bank_id;
  logic rank_id;
  logic [NOW_W-1:0] now_cycle;
  modport source (output valid, kind, command, bank_id, rank_id, now_cycle, input ready);
  modport sink (input valid, kind, command, bank_id, rank_id, now_cycle, output ready);
endinterface

interface dctc_out_if import dctc_pkg::*; ();
  logic valid;
  logic ready;
  logic [NOW_W-1:0] earliest_cycle;
  modport source (output valid, earliest_cycle, input ready);
  modport sink (input valid, earliest_cycle, output ready);
endinterface

// File: rtl/core/dctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/dctc_ctrl.sv
// Controller: clearing pass, item acceptance, check-list sequencing, drain and
// result hand-off. Depends on dctc_pkg.
`timescale 1ns / 1ps
module dctc_ctrl import dctc_pkg::*; #(
  parameter int BANKS = DEF_BANKS,
  parameter int RANKS = DEF_RANKS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  dctc_sts_t sts,
  output dctc_ctl_t ctl,
  output logic [$clog2(NCMD * (BANKS > RANKS ? BANKS : RANKS))-1:0] clr_addr
);
  localparam int CLR_N = NCMD * (BANKS > RANKS ? BANKS : RANKS);
  localparam int CLR_W = $clog2(CLR_N);

  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_STEP = 3'd2, S_DRAIN = 3'd3,
    S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [IDX_W-1:0] idx;
  logic accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    ctl.clr = (state == S_CLEAR);
    ctl.load = accept && !in_kind;
    ctl.record = accept && in_kind;
    ctl.step = (state == S_STEP) && !sts.list_end;
    ctl.finish = (state == S_DONE) && sts.out_free;
    ctl.idx = idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == CLR_W'(CLR_N - 1)) state_next = S_IDLE;
      S_IDLE: if (accept && !in_kind) state_next = S_STEP;
      S_STEP: if (sts.list_end) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (ctl.load) begin
        idx <= '0;
      end else if (ctl.step) begin
        idx <= idx + 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/dctc_dp.sv
// Datapath: configuration, issue-history tables, activate windows, delay
// derivation, three-stage bound pipeline and result register.
// Depends on dctc_pkg and dctc_ram.
`timescale 1ns / 1ps
module dctc_dp import dctc_pkg::*; #(
  parameter int BANKS = DEF_BANKS,
  parameter int RANKS = DEF_RANKS,
  parameter int ACT_WINDOW = DEF_ACT_WINDOW,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [CMD_W-1:0] in_command,
  input  logic [3:0] in_bank_id,
  input  logic in_rank_id,
  input  logic [NOW_W-1:0] in_now_cycle,
  input  dctc_ctl_t ctl,
  input  logic [$clog2(NCMD * (BANKS > RANKS ? BANKS : RANKS))-1:0] clr_addr,
  output dctc_sts_t sts,
  input  logic out_ready,
  output logic out_valid,
  output logic [NOW_W-1:0] out_earliest
);
  localparam int TB = TIME_BITS;
  localparam int BANK_W = BANKS > 1 ? $clog2(BANKS) : 1;
  localparam int RANK_W = RANKS > 1 ? $clog2(RANKS) : 1;
  localparam int BD = NCMD * BANKS;
  localparam int RD = NCMD * RANKS;
  localparam int BA_W = $clog2(BD);
  localparam int RA_W = $clog2(RD);
  localparam int CLR_W = $clog2(NCMD * (BANKS > RANKS ? BANKS : RANKS));
  localparam int WIN_W = $clog2(ACT_WINDOW);
  localparam int CNT_W = $clog2(ACT_WINDOW + 1);
  localparam int DW = 18;

  logic [59:0] tw0, tw1, tw2, tw3, tw4, cmd_len;
  logic [35:0] tw5;

  logic [CMD_W-1:0] q_cmd;
  logic [BANK_W-1:0] q_bank;
  logic [RANK_W-1:0] q_rank;
  logic [TB-1:0] best;

  logic [TB-1:0] cmd_t [NCMD];
  logic [NCMD-1:0] cmd_v;
  logic [TB-1:0] bus_t;
  logic bus_v;
  logic [TB-1:0] win [RANKS][ACT_WINDOW];
  logic [WIN_W-1:0] head [RANKS];
  logic [CNT_W-1:0] cnt [RANKS];

  function automatic logic [BANK_W-1:0] bank_mod(input logic [3:0] b);
    logic [10:0] v;
    v = 11'(b);
    for (int s = 3; s >= 0; s--) begin
      if (v >= (11'(BANKS) << s)) v = v - (11'(BANKS) << s);
    end
    return BANK_W'(v);
  endfunction

  function automatic logic [TB-1:0] shift_time(input logic [TB-1:0] t,
                                               input logic signed [DW-1:0] d);
    logic signed [TB+1:0] s;
    s = $signed({2'b00, t}) + (TB+2)'(d);
    if (s < 0) return '0;
    if (s > $signed({2'b00, {TB{1'b1}}})) return {TB{1'b1}};
    return s[TB-1:0];
  endfunction

  // Record side.
  logic [BANK_W-1:0] r_bank;
  logic [RANK_W-1:0] r_rank;
  logic [TB-1:0] r_now, r_busy;
  logic r_ok;
  logic [3:0] r_len;

  assign r_bank = bank_mod(in_bank_id);
  assign r_rank = (RANKS > 1) ? RANK_W'(in_rank_id) : '0;
  assign r_now = TB'(in_now_cycle);
  assign r_ok = ctl.record && (in_command < CMD_W'(NCMD));
  assign r_len = cmd_len[{in_command, 2'b00} +: 4];
  assign r_busy = shift_time(r_now, $signed({{(DW-4){1'b0}}, r_len}));

  // Query check list and table reads.
  chk_t e;
  assign e = check_entry(q_cmd, ctl.idx);

  logic b_we, r_we;
  logic [BA_W-1:0] b_waddr, b_raddr;
  logic [RA_W-1:0] r_waddr, r_raddr;
  logic [TB:0] b_wdata, r_wdata, b_rdata, r_rdata;

  always_comb begin
    b_we = ctl.clr || r_ok;
    r_we = (ctl.clr && (clr_addr < CLR_W'(RD))) || r_ok;
    b_waddr = ctl.clr ? BA_W'(clr_addr) : BA_W'(32'(in_command) * BANKS + 32'(r_bank));
    r_waddr = ctl.clr ? RA_W'(clr_addr) : RA_W'(32'(in_command) * RANKS + 32'(r_rank));
    b_wdata = ctl.clr ? '0 : {1'b1, r_now};
    r_wdata = ctl.clr ? '0 : {1'b1, r_now};
    b_raddr = BA_W'(32'(e.src) * BANKS + 32'(q_bank));
    r_raddr = RA_W'(32'(e.src) * RANKS + 32'(q_rank));
  end

  dctc_ram #(.WIDTH(TB + 1), .DEPTH(BD)) u_bank_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  dctc_ram #(.WIDTH(TB + 1), .DEPTH(RD)) u_rank_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // Raw timing fields and derived delays.
  logic signed [DW-1:0] rcd, ccd, rtrs, xp, rcpb, rrd, rppb, rpab, rfcab, rfcpb;
  logic signed [DW-1:0] xsr, faw, ras, ppd, cke, sr, rl, wl, dqsck, wpre;
  logic signed [DW-1:0] rpst, wtr, rtp, wr, cmdcke, dqss, dqs2dq, bl;
  logic signed [DW-1:0] rdpre, wrpre, rdpden, wrapden, dly;

  assign rcd = DW'(tw0[11:0]);   assign ccd = DW'(tw0[23:12]);
  assign rtrs = DW'(tw0[35:24]); assign xp = DW'(tw0[47:36]);
  assign rcpb = DW'(tw0[59:48]);
  assign rrd = DW'(tw1[11:0]);   assign rppb = DW'(tw1[23:12]);
  assign rpab = DW'(tw1[35:24]); assign rfcab = DW'(tw1[47:36]);
  assign rfcpb = DW'(tw1[59:48]);
  assign xsr = DW'(tw2[11:0]);   assign faw = DW'(tw2[23:12]);
  assign ras = DW'(tw2[35:24]);  assign ppd = DW'(tw2[47:36]);
  assign cke = DW'(tw2[59:48]);
  assign sr = DW'(tw3[11:0]);    assign rl = DW'(tw3[23:12]);
  assign wl = DW'(tw3[35:24]);   assign dqsck = DW'(tw3[47:36]);
  assign wpre = DW'(tw3[59:48]);
  assign rpst = DW'(tw4[11:0]);  assign wtr = DW'(tw4[23:12]);
  assign rtp = DW'(tw4[35:24]);  assign wr = DW'(tw4[47:36]);
  assign cmdcke = DW'(tw4[59:48]);
  assign dqss = DW'(tw5[11:0]);  assign dqs2dq = DW'(tw5[23:12]);
  assign bl = DW'(tw5[35:24]);

  assign rdpre = rtp + bl - 18'sd6;
  assign wrpre = wl + bl + wr + 18'sd3;
  assign rdpden = rl + dqsck + bl + rpst + 18'sd3;
  assign wrapden = wl + dqss + dqs2dq + bl + wr + 18'sd5;

  always_comb begin
    case (e.dly)
      D_RCD: dly = rcd;
      D_CCD: dly = ccd;
      D_RDWR: dly = rl + dqsck + bl - wl + wpre + rpst;
      D_BRTRS: dly = bl + rtrs;
      D_RDWR_R: dly = rl + bl + rtrs - wl;
      D_WRPRE_RDPRE: dly = wrpre - rdpre;
      D_WRRD: dly = wl + bl + wtr + 18'sd1;
      D_WRRD_R: dly = wl + bl + rtrs - rl;
      D_XP: dly = xp;
      D_RCPB: dly = rcpb;
      D_RRD: dly = rrd;
      D_RDAACT: dly = rtp + bl + rppb - 18'sd8;
      D_WRAACT: dly = wl + bl + wr + rppb + 18'sd1;
      D_RPPB_M2: dly = rppb - 18'sd2;
      D_RPAB_M2: dly = rpab - 18'sd2;
      D_RFCAB_M2: dly = rfcab - 18'sd2;
      D_RFCPB_M2: dly = rfcpb - 18'sd2;
      D_RRD_M2: dly = rrd - 18'sd2;
      D_XSR_M2: dly = xsr - 18'sd2;
      D_FAW_M4: dly = faw - 18'sd4;
      D_RAS_P2: dly = ras + 18'sd2;
      D_RDPRE: dly = rdpre;
      D_WRPRE: dly = wrpre;
      D_PPD: dly = ppd;
      D_RFCPB: dly = rfcpb;
      D_RCPB_P2: dly = rcpb + 18'sd2;
      D_RDPRE_RPPB: dly = rdpre + rppb;
      D_WRPRE_RPPB: dly = wrpre + rppb;
      D_RPPB: dly = rppb;
      D_RPAB: dly = rpab;
      D_RFCAB: dly = rfcab;
      D_XSR: dly = xsr;
      D_RRD_P2: dly = rrd + 18'sd2;
      D_FAW_M2: dly = faw - 18'sd2;
      D_ACTPDEN, D_PRPDEN, D_REFPDEN: dly = cmdcke + ((e.dly == D_ACTPDEN) ? 18'sd3 : 18'sd1);
      D_RDPDEN: dly = rdpden;
      D_WRPDEN: dly = wrapden - 18'sd2;
      D_WRAPDEN: dly = wrapden;
      D_CKE: dly = cke;
      D_SREF_RDA: dly = (rdpden > rdpre + rppb) ? rdpden : rdpre + rppb;
      D_SREF_WRA: dly = (wrapden > wrpre + rppb) ? wrapden : wrpre + rppb;
      D_SR: dly = sr;
      default: dly = '0;
    endcase
  end

  // Stage one registers, stage two candidate, stage three running maximum.
  logic s1_v, s1_cv, s1_faw_ok, s2_v;
  logic [KIND_W-1:0] s1_kind;
  logic signed [DW-1:0] s1_dly;
  logic [TB-1:0] s1_ct, s1_faw_t, s2_t, sel_t;
  logic sel_v;

  always_comb begin
    sel_v = 1'b0;
    sel_t = b_rdata[TB-1:0];
    case (s1_kind)
      K_BANK: begin
        sel_v = b_rdata[TB];
        sel_t = b_rdata[TB-1:0];
      end
      K_RANK: begin
        sel_v = r_rdata[TB];
        sel_t = r_rdata[TB-1:0];
      end
      K_OTHER: begin
        sel_v = s1_cv && (!r_rdata[TB] || (s1_ct != r_rdata[TB-1:0]));
        sel_t = s1_ct;
      end
      K_FAW: begin
        sel_v = s1_faw_ok;
        sel_t = s1_faw_t;
      end
      default: sel_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= ctl.step;
      s2_v <= s1_v && sel_v;
    end
    s1_kind <= e.kind;
    s1_dly <= dly;
    s1_cv <= cmd_v[e.src];
    s1_ct <= cmd_t[e.src];
    s1_faw_ok <= (cnt[q_rank] >= CNT_W'(ACT_WINDOW));
    s1_faw_t <= win[q_rank][head[q_rank]];
    s2_t <= shift_time(sel_t, s1_dly);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_cmd <= in_command;
      q_bank <= r_bank;
      q_rank <= r_rank;
      best <= (bus_v && (bus_t > r_now)) ? bus_t : r_now;
    end else if (s2_v && (s2_t > best)) begin
      best <= s2_t;
    end
  end

  // Configuration and record-side state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tw0 <= '0; tw1 <= '0; tw2 <= '0; tw3 <= '0; tw4 <= '0; tw5 <= '0;
      cmd_len <= '0;
      cmd_v <= '0;
      bus_v <= 1'b0;
      for (int r = 0; r < RANKS; r++) begin
        head[r] <= '0;
        cnt[r] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TW0: tw0 <= cfg_data;
          REG_TW1: tw1 <= cfg_data;
          REG_TW2: tw2 <= cfg_data;
          REG_TW3: tw3 <= cfg_data;
          REG_TW4: tw4 <= cfg_data;
          REG_TW5: tw5 <= cfg_data[35:0];
          REG_CMDLEN: cmd_len <= cfg_data;
          default: ;
        endcase
      end
      if (r_ok) begin
        cmd_v[in_command] <= 1'b1;
        bus_v <= 1'b1;
        if ((in_command == C_ACT) || (in_command == C_REFPB)) begin
          if (cnt[r_rank] >= CNT_W'(ACT_WINDOW)) begin
            head[r_rank] <= head[r_rank] + 1'b1;
          end else begin
            cnt[r_rank] <= cnt[r_rank] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_ok) begin
      cmd_t[in_command] <= r_now;
      bus_t <= r_busy;
      if ((in_command == C_ACT) || (in_command == C_REFPB)) begin
        if (cnt[r_rank] >= CNT_W'(ACT_WINDOW)) begin
          win[r_rank][head[r_rank]] <= r_busy;
        end else begin
          win[r_rank][head[r_rank] + WIN_W'(cnt[r_rank])] <= r_busy;
        end
      end
    end
  end

  // Result register.
  assign sts = '{list_end: (e.kind == K_END), out_free: (!out_valid || out_ready)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.finish) begin
      out_earliest <= NOW_W'(best);
    end
  end
endmodule

// File: rtl/core/dram_command_timing_checker.sv
// DRAM command timing checker, top level: controller, datapath and assertions.
// Depends on dctc_pkg, dctc_if, dctc_ram, dctc_ctrl and dctc_dp.
//
// Usage: items arrive on in_ch. A query item (kind 0) yields one result on
// out_ch, the earliest legal issue cycle of the named command; a record item
// (kind 1) updates the issue history and yields no result.
// Timing registers are written through cfg_we/cfg_index/cfg_data while idle.
// A record keeps the controller idle, ready for the next item. A query walks
// the command's constraint list, one entry per cycle through the table read
// port and a three-stage bound pipeline (at most 13 entries); the pipeline
// then drains and the result is handed to the output register before the
// next item is taken, so no item is accepted while a query is in progress.
// After reset the history memories are cleared, one entry per cycle, over
// 15 * max(BANKS, RANKS) entries; in_ch.ready stays low during that pass.
// The result sits in an output register; a new item is accepted while it
// waits, and a following query holds at its end until out_ch takes the
// earlier result.
`timescale 1ns / 1ps
module dram_command_timing_checker import dctc_pkg::*; #(
  parameter int BANKS = DEF_BANKS,
  parameter int RANKS = DEF_RANKS,
  parameter int ACT_WINDOW = DEF_ACT_WINDOW,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic clk,
  input  logic rst,
  dctc_in_if.sink in_ch,
  dctc_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam int CLR_W = $clog2(NCMD * (BANKS > RANKS ? BANKS : RANKS));

  dctc_ctl_t ctl;
  dctc_sts_t sts;
  logic [CLR_W-1:0] clr_addr;

  dctc_ctrl #(.BANKS(BANKS), .RANKS(RANKS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_kind(in_ch.kind),
    .in_ready(in_ch.ready), .sts(sts), .ctl(ctl), .clr_addr(clr_addr)
  );

  dctc_dp #(
    .BANKS(BANKS), .RANKS(RANKS), .ACT_WINDOW(ACT_WINDOW), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_command(in_ch.command), .in_bank_id(in_ch.bank_id), .in_rank_id(in_ch.rank_id),
    .in_now_cycle(in_ch.now_cycle), .ctl(ctl), .clr_addr(clr_addr), .sts(sts),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_earliest(out_ch.earliest_cycle)
  );

`ifndef SYNTHESIS
  a_record_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.kind) |=> in_ch.ready)
    else $error("record item did not complete in one cycle");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !in_ch.kind) |=> !in_ch.ready)
    else $error("input accepted while a query is in progress");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> out_ch.valid)
    else $error("finished query did not present a result");
`endif
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for dram_command_timing_checker: queries and records
// are driven with random idling and stalls, and each earliest-cycle result is
// checked against an in-bench timing predictor. Depends on dctc_pkg and dctc_if.
`timescale 1ns / 1ps
module tb;
  import dctc_pkg::*;

  localparam logic [NOW_W-1:0] TMAX = {NOW_W{1'b1}};

  typedef struct {
    bit hold;
    logic kind;
    logic [CMD_W-1:0] command;
    logic [3:0] bank_id;
    logic rank_id;
    logic [NOW_W-1:0] now_cycle;
  } item_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dctc_in_if in_ch();
  dctc_out_if out_ch();

  dram_command_timing_checker u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  item_t pending_items[$];
  logic [NOW_W-1:0] earliest_q[$];
  int send_idle_pct, recv_stall_pct;
  int mismatches;
  bit took;

  logic [CFG_W-1:0] tword[6];
  logic [CFG_W-1:0] cmd_len;
  logic [NOW_W-1:0] t_bank[NCMD][16];
  bit v_bank[NCMD][16];
  logic [NOW_W-1:0] t_rank[NCMD][2];
  bit v_rank[NCMD][2];
  logic [NOW_W-1:0] t_any[NCMD];
  bit v_any[NCMD];
  logic [NOW_W-1:0] bus_t;
  bit bus_v;
  logic [NOW_W-1:0] act_win[2][4];
  int act_head[2], act_cnt[2];
  int q_bank, q_rank;
  logic [NOW_W-1:0] best;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint fld(int w, int i);
    return longint'((tword[w] >> (12 * i)) & 60'hfff);
  endfunction

  function automatic logic [NOW_W-1:0] shift_t(logic [NOW_W-1:0] t, longint d);
    longint unsigned ud;
    if (d >= 0) begin
      ud = d;
      if (ud > longint'(TMAX - t)) return TMAX;
      return NOW_W'(t + ud);
    end
    ud = -d;
    if (ud > t) return '0;
    return NOW_W'(t - ud);
  endfunction

  function automatic void bound(bit v, logic [NOW_W-1:0] t, longint d);
    logic [NOW_W-1:0] c;
    if (v) begin
      c = shift_t(t, d);
      if (c > best) best = c;
    end
  endfunction

  function automatic void bk(int c, longint d);
    bound(v_bank[c][q_bank], t_bank[c][q_bank], d);
  endfunction

  function automatic void rk(int c, longint d);
    bound(v_rank[c][q_rank], t_rank[c][q_rank], d);
  endfunction

  function automatic void ot(int c, longint d);
    if (v_any[c] != v_rank[c][q_rank] || (v_any[c] && t_any[c] != t_rank[c][q_rank]))
      bound(v_any[c], t_any[c], d);
  endfunction

  function automatic void fw(longint d);
    if (act_cnt[q_rank] >= 4) bound(1'b1, act_win[q_rank][act_head[q_rank]], d);
  endfunction

  function automatic logic [NOW_W-1:0] predict_earliest(logic [CMD_W-1:0] cmd,
                                                        logic [NOW_W-1:0] now);
    longint rcd, ccd, rtrs, xp, rcpb, rrd, rppb, rpab, rfcab, rfcpb;
    longint xsr, faw, ras, ppd, cke, sr, rl, wl, dqsck, wpre;
    longint rpst, wtr, rtp, wr, cmdcke, dqss, dqs2dq, b;
    longint rdwr, rdwr_r, wrrd, wrrd_r, rdpre, rdaact, wrpre, wraact;
    longint actpden, prpden, rdpden, wrpden, wrapden, refpden;
    bit rd;
    rcd = fld(0, 0); ccd = fld(0, 1); rtrs = fld(0, 2); xp = fld(0, 3); rcpb = fld(0, 4);
    rrd = fld(1, 0); rppb = fld(1, 1); rpab = fld(1, 2); rfcab = fld(1, 3); rfcpb = fld(1, 4);
    xsr = fld(2, 0); faw = fld(2, 1); ras = fld(2, 2); ppd = fld(2, 3); cke = fld(2, 4);
    sr = fld(3, 0); rl = fld(3, 1); wl = fld(3, 2); dqsck = fld(3, 3); wpre = fld(3, 4);
    rpst = fld(4, 0); wtr = fld(4, 1); rtp = fld(4, 2); wr = fld(4, 3); cmdcke = fld(4, 4);
    dqss = fld(5, 0); dqs2dq = fld(5, 1); b = fld(5, 2);
    rdwr = rl + dqsck + b - wl + wpre + rpst;
    rdwr_r = rl + b + rtrs - wl;
    wrrd = wl + 1 + b + wtr;
    wrrd_r = wl + b + rtrs - rl;
    rdpre = rtp + b - 6;
    rdaact = rtp + b - 8 + rppb;
    wrpre = wl + b + 1 + wr + 2;
    wraact = wl + b + 1 + wr + rppb;
    actpden = 3 + cmdcke;
    prpden = 1 + cmdcke;
    rdpden = 3 + rl + dqsck + b + rpst;
    wrpden = 3 + wl + dqss + dqs2dq + b + wr;
    wrapden = wrpden + 2;
    refpden = 1 + cmdcke;
    best = now;
    case (cmd)
      C_RD, C_WR, C_RDA, C_WRA: begin
        rd = (cmd == C_RD) || (cmd == C_RDA);
        bk(C_ACT, rcd);
        rk(C_RD, rd ? ccd : rdwr); ot(C_RD, rd ? b + rtrs : rdwr_r);
        rk(C_RDA, rd ? ccd : rdwr); ot(C_RDA, rd ? b + rtrs : rdwr_r);
        if (cmd == C_RDA) bk(C_WR, wrpre - rdpre);
        rk(C_WR, rd ? wrrd : ccd); ot(C_WR, rd ? wrrd_r : b + rtrs);
        rk(C_WRA, rd ? wrrd : ccd); ot(C_WRA, rd ? wrrd_r : b + rtrs);
        rk(C_PDXA, xp);
      end
      C_ACT: begin
        bk(C_ACT, rcpb); rk(C_ACT, rrd); bk(C_RDA, rdaact); bk(C_WRA, wraact);
        bk(C_PREPB, rppb - 2); rk(C_PREAB, rpab - 2); rk(C_PDXA, xp); rk(C_PDXP, xp);
        rk(C_REFAB, rfcab - 2); bk(C_REFPB, rfcpb - 2); rk(C_REFPB, rrd - 2);
        rk(C_SREFEX, xsr - 2); fw(faw - 4);
      end
      C_PREPB: begin
        bk(C_ACT, ras + 2); bk(C_RD, rdpre); bk(C_WR, wrpre); rk(C_PREPB, ppd);
        rk(C_PDXA, xp);
      end
      C_PREAB: begin
        rk(C_ACT, ras + 2); rk(C_RD, rdpre); rk(C_RDA, rdpre); rk(C_WR, wrpre);
        rk(C_WRA, wrpre); rk(C_PREPB, ppd); rk(C_PDXA, xp); rk(C_REFPB, rfcpb);
      end
      C_REFAB: begin
        rk(C_ACT, rcpb + 2); rk(C_RDA, rdpre + rppb); rk(C_WRA, wrpre + rppb);
        rk(C_PREPB, rppb); rk(C_PREAB, rpab); rk(C_PDXP, xp); rk(C_REFAB, rfcab);
        rk(C_REFPB, rfcpb); rk(C_SREFEX, xsr);
      end
      C_REFPB: begin
        bk(C_ACT, rcpb + 2); rk(C_ACT, rrd + 2); bk(C_RDA, rdpre + rppb);
        bk(C_WRA, wrpre + rppb); bk(C_PREPB, rppb); rk(C_PREAB, rpab); rk(C_PDXA, xp);
        rk(C_PDXP, xp); rk(C_REFAB, rfcab); rk(C_REFPB, rfcpb); rk(C_SREFEX, xsr);
        fw(faw - 2);
      end
      C_PDEA: begin
        rk(C_ACT, actpden); rk(C_RD, rdpden); rk(C_RDA, rdpden); rk(C_WR, wrpden);
        rk(C_WRA, wrapden); rk(C_PREPB, prpden); rk(C_REFPB, refpden); rk(C_PDXA, cke);
      end
      C_PDXA: rk(C_PDEA, cke);
      C_PDEP: begin
        rk(C_RD, rdpden); rk(C_RDA, rdpden); rk(C_WRA, wrapden); rk(C_PREPB, prpden);
        rk(C_PREAB, prpden); rk(C_REFAB, refpden); rk(C_REFPB, refpden); rk(C_PDXP, cke);
        rk(C_SREFEX, xsr);
      end
      C_PDXP: rk(C_PDEP, cke);
      C_SREFEN: begin
        rk(C_ACT, rcpb + 2);
        rk(C_RDA, rdpden > rdpre + rppb ? rdpden : rdpre + rppb);
        rk(C_WRA, wrapden > wrpre + rppb ? wrapden : wrpre + rppb);
        rk(C_PREPB, rppb); rk(C_PREAB, rpab); rk(C_PDXP, xp); rk(C_REFAB, rfcab);
        rk(C_REFPB, rfcpb); rk(C_SREFEX, xsr);
      end
      C_SREFEX: rk(C_SREFEN, sr);
      default: ;
    endcase
    bound(bus_v, bus_t, 0);
    return best;
  endfunction

  function automatic void record_issue(logic [CMD_W-1:0] cmd, logic [NOW_W-1:0] now);
    int r;
    if (cmd >= NCMD) return;
    r = q_rank;
    t_bank[cmd][q_bank] = now; v_bank[cmd][q_bank] = 1'b1;
    t_rank[cmd][r] = now; v_rank[cmd][r] = 1'b1;
    t_any[cmd] = now; v_any[cmd] = 1'b1;
    bus_t = shift_t(now, longint'((cmd_len >> (4 * cmd)) & 60'hf));
    bus_v = 1'b1;
    if (cmd == C_ACT || cmd == C_REFPB) begin
      if (act_cnt[r] >= 4) begin
        act_win[r][act_head[r]] = bus_t;
        act_head[r] = (act_head[r] + 1) % 4;
      end else begin
        act_win[r][(act_head[r] + act_cnt[r]) % 4] = bus_t;
        act_cnt[r]++;
      end
    end
  endfunction

  always @(posedge clk) begin
    took = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        took = 1'b1;
        q_bank = int'(in_ch.bank_id);
        q_rank = int'(in_ch.rank_id);
        if (in_ch.kind == 1'b0)
          earliest_q.push_back(predict_earliest(in_ch.command, in_ch.now_cycle));
        else
          record_issue(in_ch.command, in_ch.now_cycle);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (earliest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %0d", out_ch.earliest_cycle);
        end else begin
          if (out_ch.earliest_cycle !== earliest_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("earliest_cycle mismatch: expected %0d, got %0d",
                       earliest_q[0], out_ch.earliest_cycle);
          end
          void'(earliest_q.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (!in_ch.valid || took) begin
        if (pending_items.size() > 0 && pending_items[0].hold && earliest_q.size() > 0) begin
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     $urandom_range(99, 0) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.kind <= pending_items[0].kind;
          in_ch.command <= pending_items[0].command;
          in_ch.bank_id <= pending_items[0].bank_id;
          in_ch.rank_id <= pending_items[0].rank_id;
          in_ch.now_cycle <= pending_items[0].now_cycle;
          void'(pending_items.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic add_item(logic kind, logic [CMD_W-1:0] cmd, logic [3:0] bank,
                          logic rank, logic [NOW_W-1:0] now, bit hold = 1'b0);
    item_t it;
    it.hold = hold; it.kind = kind; it.command = cmd; it.bank_id = bank;
    it.rank_id = rank; it.now_cycle = now;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_ch.valid || earliest_q.size() > 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    if (idx == REG_CMDLEN) cmd_len = data;
    else if (idx == REG_TW5) tword[5] = data & 60'hf_ffff_ffff;
    else tword[idx] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] rand_delay();
    int p;
    p = $urandom_range(99, 0);
    if (p < 4) return 12'hfff;
    if (p < 8) return 12'h000;
    return 12'($urandom_range(40, 0));
  endfunction

  task automatic write_timing(int style);
    logic [CFG_W-1:0] w;
    for (int r = 0; r < 6; r++) begin
      for (int f = 0; f < 5; f++) w[12*f +: 12] = rand_delay();
      if (style == 0) w = '0;
      if (style == 1) w = '1;
      write_reg(r[CFG_IDX_W-1:0], w);
    end
    w = CFG_W'({$urandom, $urandom});
    if (style == 0) w = '0;
    if (style == 1) w = '1;
    write_reg(REG_CMDLEN, w);
  endtask

  task automatic make_traffic(int n, logic [NOW_W-1:0] start);
    logic [NOW_W-1:0] tnow;
    logic [3:0] cmd;
    tnow = start;
    for (int i = 0; i < n; i++) begin
      tnow = tnow + NOW_W'($urandom_range(12, 0));
      cmd = 4'($urandom_range(NCMD - 1, 0));
      if ($urandom_range(99, 0) < 4) cmd = 4'hf;
      if ($urandom_range(99, 0) < 5)
        add_item(1'($urandom_range(1, 0)), cmd, 4'($urandom_range(15, 0)),
                 1'($urandom_range(1, 0)),
                 {8'($urandom_range(255, 0)), 32'($urandom)});
      else
        add_item($urandom_range(99, 0) < 45, cmd, 4'($urandom_range(15, 0)),
                 1'($urandom_range(1, 0)), tnow - NOW_W'($urandom_range(3, 0)),
                 $urandom_range(999, 0) < 3);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.kind = 1'b0; in_ch.command = '0; in_ch.bank_id = '0;
    in_ch.rank_id = 1'b0; in_ch.now_cycle = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; mismatches = 0;
    for (int i = 0; i < 6; i++) tword[i] = '0;
    cmd_len = '0;
    for (int c = 0; c < NCMD; c++) begin
      v_any[c] = 1'b0;
      for (int b = 0; b < 16; b++) v_bank[c][b] = 1'b0;
      for (int r = 0; r < 2; r++) v_rank[c][r] = 1'b0;
    end
    bus_v = 1'b0; act_head = '{0, 0}; act_cnt = '{0, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_timing(2);
    for (int c = 0; c < 16; c++) add_item(1'b0, 4'(c), 4'h0, 1'b0, 40'd100);
    add_item(1'b1, C_ACT, 4'hf, 1'b1, '0);
    add_item(1'b0, C_RD, 4'hf, 1'b1, '0);
    add_item(1'b1, C_WR, 4'ha, 1'b0, TMAX);
    add_item(1'b0, C_WR, 4'h5, 1'b0, TMAX);
    add_item(1'b1, 4'hf, 4'h3, 1'b1, 40'd7);
    add_item(1'b0, C_RDA, 4'ha, 1'b1, 40'h55_5555_5555);
    add_item(1'b0, C_PREAB, 4'h0, 1'b0, 40'd3, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_timing(ph < 2 ? ph : 2);
      make_traffic(185, ph == 5 ? TMAX - 40'd1500 : 40'($urandom_range(100000, 0)));
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
